FILE: rtl/pxa_pkg.sv
// shared operation codes and pipeline stage types for the rgba pixel alu
package pxa_pkg;

  localparam int unsigned NumChan  = 4;
  localparam logic [7:0]  ChanMax  = 8'd255;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_GAIN_MUL = 4'd2,
    OP_GAIN_DIV = 4'd3,
    OP_NORM_MUL = 4'd4,
    OP_NORM_DIV = 4'd5,
    OP_MIN     = 4'd6,
    OP_MAX     = 4'd7,
    OP_WRAP_ADD = 4'd8,
    OP_SWAP    = 4'd9
  } op_t;

  // first stage: products and divider set-up per channel
  typedef struct packed {
    logic        is_div;
    logic        is_gmul;
    logic        is_nmul;
    logic        zero;
    logic [7:0]  simple;
    logic [22:0] prod;
    logic [15:0] rem;
    logic [14:0] den;
  } s1_t;

  // later stages: finished result or divider in progress
  typedef struct packed {
    logic        is_div;
    logic        zero;
    logic        sat;
    logic [7:0]  res;
    logic [7:0]  q;
    logic [15:0] rem;
    logic [14:0] den;
  } dv_t;

  // one restoring step: quotient bit above the new remainder
  function automatic logic [16:0] div_step(logic [15:0] rem, logic [14:0] den,
                                           logic [2:0] sh);
    logic [23:0] d;
    logic [23:0] r;
    d = {9'b0, den} << sh;
    r = {8'b0, rem};
    if (r >= d) begin
      return {1'b1, 16'(r - d)};
    end else begin
      return {1'b0, rem};
    end
  endfunction

endpackage

FILE: rtl/saturating_rgba_pixel_alu.sv
// top level of the saturating rgba8 pixel alu, five register stages
//
// One pixel word enters per cycle when the output side is not stalled, and its result
// leaves the fifth stage. Stage one forms the channel products (one 8x15 multiplier
// per channel) and the simple results; stages two to five each run two steps of a
// restoring divider per channel for the divide operations, whose quotient is limited to
// eight bits after an up-front saturation check. Each stage holds its word until the
// next one frees, so a stall at the output fills the bubbles before input stops.
module saturating_rgba_pixel_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // red, green, blue, alpha pixel bytes, then red, green, blue, alpha operands
  input  logic [95:0] in_tdata,
  // operation
  input  logic [3:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [31:0] out_tdata
);

  pxa_pkg::s1_t s1_r [pxa_pkg::NumChan];
  pxa_pkg::s1_t s1_nxt [pxa_pkg::NumChan];
  pxa_pkg::dv_t s2_r [pxa_pkg::NumChan];
  pxa_pkg::dv_t s2_nxt [pxa_pkg::NumChan];
  pxa_pkg::dv_t s3_r [pxa_pkg::NumChan];
  pxa_pkg::dv_t s3_nxt [pxa_pkg::NumChan];
  pxa_pkg::dv_t s4_r [pxa_pkg::NumChan];
  pxa_pkg::dv_t s4_nxt [pxa_pkg::NumChan];
  logic [31:0]  out_r;
  logic [31:0]  out_nxt;
  logic         v1_r, v2_r, v3_r, v4_r, v5_r;
  logic         rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_r || out_tready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready  = rdy1;
  assign out_tvalid = v5_r;
  assign out_tdata  = out_r;

  // stage one
  always_comb begin
    pxa_pkg::op_t op;
    logic [7:0]   p;
    logic [15:0]  v;
    logic [7:0]   b;
    logic [14:0]  m;
    logic signed [17:0] s;
    op = pxa_pkg::op_t'(in_tuser);
    for (int c = 0; c < pxa_pkg::NumChan; c++) begin
      p = in_tdata[8*c +: 8];
      v = in_tdata[32 + 16*c +: 16];
      b = v[7:0];
      s1_nxt[c].is_div  = (op == pxa_pkg::OP_GAIN_DIV) || (op == pxa_pkg::OP_NORM_DIV);
      s1_nxt[c].is_gmul = (op == pxa_pkg::OP_GAIN_MUL);
      s1_nxt[c].is_nmul = (op == pxa_pkg::OP_NORM_MUL);
      s1_nxt[c].zero    = (op == pxa_pkg::OP_NORM_DIV) ? (b == 8'd0)
                                                       : (v[15] || v == 16'd0);
      m = (op == pxa_pkg::OP_NORM_MUL) ? {7'b0, b} : v[14:0];
      s1_nxt[c].prod = 23'(p) * 23'(m);
      if (op == pxa_pkg::OP_NORM_DIV) begin
        s1_nxt[c].rem = {p, 8'b0} - {8'b0, p};
        s1_nxt[c].den = {7'b0, b};
      end else begin
        s1_nxt[c].rem = {p, 8'b0};
        s1_nxt[c].den = v[14:0];
      end
      s = '0;
      unique case (op)
        pxa_pkg::OP_ADD: s = $signed({10'b0, p}) + $signed({{2{v[15]}}, v});
        pxa_pkg::OP_SUB: s = $signed({10'b0, p}) - $signed({{2{v[15]}}, v});
        default:         s = '0;
      endcase
      unique case (op)
        pxa_pkg::OP_ADD, pxa_pkg::OP_SUB: begin
          if (s < 0) s1_nxt[c].simple = 8'd0;
          else if (s > 18'sd255) s1_nxt[c].simple = pxa_pkg::ChanMax;
          else s1_nxt[c].simple = s[7:0];
        end
        pxa_pkg::OP_MIN:      s1_nxt[c].simple = (p < b) ? p : b;
        pxa_pkg::OP_MAX:      s1_nxt[c].simple = (p > b) ? p : b;
        pxa_pkg::OP_WRAP_ADD: s1_nxt[c].simple = p + b;
        pxa_pkg::OP_SWAP: begin
          if (c == 0) s1_nxt[c].simple = in_tdata[23:16];
          else if (c == 2) s1_nxt[c].simple = in_tdata[7:0];
          else s1_nxt[c].simple = p;
        end
        default:              s1_nxt[c].simple = p;
      endcase
    end
  end

  // stage two: finish the multiplies, saturation check, quotient bits 7 and 6
  always_comb begin
    logic [16:0] st;
    logic [16:0] nm;
    for (int c = 0; c < pxa_pkg::NumChan; c++) begin
      nm = {1'b0, s1_r[c].prod[15:0]} + {9'b0, s1_r[c].prod[15:8]} + 17'd1;
      if (s1_r[c].is_gmul) begin
        if (s1_r[c].zero) s2_nxt[c].res = 8'd0;
        else if (s1_r[c].prod[22:16] != 7'd0) s2_nxt[c].res = pxa_pkg::ChanMax;
        else s2_nxt[c].res = s1_r[c].prod[15:8];
      end else if (s1_r[c].is_nmul) begin
        s2_nxt[c].res = nm[15:8];
      end else begin
        s2_nxt[c].res = s1_r[c].simple;
      end
      s2_nxt[c].is_div = s1_r[c].is_div;
      s2_nxt[c].zero   = s1_r[c].zero;
      s2_nxt[c].sat    = {7'b0, s1_r[c].rem[15:8]} >= s1_r[c].den;
      s2_nxt[c].den    = s1_r[c].den;
      s2_nxt[c].q      = '0;
      st = pxa_pkg::div_step(s1_r[c].rem, s1_r[c].den, 3'd7);
      s2_nxt[c].q[7] = st[16];
      st = pxa_pkg::div_step(st[15:0], s1_r[c].den, 3'd6);
      s2_nxt[c].q[6] = st[16];
      s2_nxt[c].rem  = st[15:0];
    end
  end

  always_comb begin
    logic [16:0] st;
    for (int c = 0; c < pxa_pkg::NumChan; c++) begin
      s3_nxt[c] = s2_r[c];
      st = pxa_pkg::div_step(s2_r[c].rem, s2_r[c].den, 3'd5);
      s3_nxt[c].q[5] = st[16];
      st = pxa_pkg::div_step(st[15:0], s2_r[c].den, 3'd4);
      s3_nxt[c].q[4] = st[16];
      s3_nxt[c].rem  = st[15:0];
    end
  end

  always_comb begin
    logic [16:0] st;
    for (int c = 0; c < pxa_pkg::NumChan; c++) begin
      s4_nxt[c] = s3_r[c];
      st = pxa_pkg::div_step(s3_r[c].rem, s3_r[c].den, 3'd3);
      s4_nxt[c].q[3] = st[16];
      st = pxa_pkg::div_step(st[15:0], s3_r[c].den, 3'd2);
      s4_nxt[c].q[2] = st[16];
      s4_nxt[c].rem  = st[15:0];
    end
  end

  // last two quotient bits and the final selection
  always_comb begin
    logic [16:0] st;
    logic [7:0]  q;
    for (int c = 0; c < pxa_pkg::NumChan; c++) begin
      q = s4_r[c].q;
      st = pxa_pkg::div_step(s4_r[c].rem, s4_r[c].den, 3'd1);
      q[1] = st[16];
      st = pxa_pkg::div_step(st[15:0], s4_r[c].den, 3'd0);
      q[0] = st[16];
      if (!s4_r[c].is_div) out_nxt[8*c +: 8] = s4_r[c].res;
      else if (s4_r[c].zero) out_nxt[8*c +: 8] = 8'd0;
      else if (s4_r[c].sat) out_nxt[8*c +: 8] = pxa_pkg::ChanMax;
      else out_nxt[8*c +: 8] = q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1_r <= s1_nxt;
    if (rdy2) s2_r <= s2_nxt;
    if (rdy3) s3_r <= s3_nxt;
    if (rdy4) s4_r <= s4_nxt;
    if (rdy5) out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  // an empty first stage never holds off the input
  a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> in_tready) else $error("input stalled with an empty first stage");

  // a word in the last divider stage reaches an empty output register next cycle
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !v5_r) |=> v5_r) else $error("word lost before the output register");

  // the output stage only refills when it was free or being taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && !out_tready) |=> (v5_r && $stable(out_tdata)))
    else $error("stalled result changed");
`endif

endmodule
